>>> rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the frustum box cull block
// plane store depth, item modes and payload widths
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned PlaneIdxW = 3;
  localparam int unsigned CoefW     = 32;
  localparam int unsigned ProdW     = 2 * CoefW;
  localparam int unsigned SumW      = ProdW + 3;
  localparam int unsigned InDataW   = 10 * CoefW + 8;
  localparam int unsigned OutDataW  = 8;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModePoint = 2'd1,
    ModeBox   = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] d;
  } plane_t;

endpackage

`default_nettype wire

>>> rtl/frustum_box_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_top: point and box visibility against six planes
// result path: 4 register stages, input register through result register
// throughput: one item per cycle while the output is not stalled,
// the six planes are tested in parallel lanes
// stages: register in, multiply, pick-max and partial sum, final sum and sign
// reset: asynchronous active low, clears valid bits and zeroes the plane store
// a plane load takes effect for every test item accepted after it
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: plane_index[2:0], coef_a, coef_b, coef_c, coef_d,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  wire logic [fbc_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: visible, zero pad
  output logic [fbc_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned NP = fbc_pkg::NumPlanes;
  localparam int unsigned CW = fbc_pkg::CoefW;
  localparam int unsigned PW = fbc_pkg::ProdW;
  localparam int unsigned SW = fbc_pkg::SumW;

  // pipeline advances whenever the output slot is free or being emptied
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // field unpack
  logic [fbc_pkg::PlaneIdxW-1:0] idx;
  fbc_pkg::plane_t               in_plane;
  logic signed [CW-1:0]          lo_in [3];
  logic signed [CW-1:0]          hi_in [3];
  fbc_pkg::mode_e                mode;

  assign mode       = fbc_pkg::mode_e'(s_axis_tuser);
  assign idx        = s_axis_tdata[2:0];
  assign in_plane.a = s_axis_tdata[3 +: CW];
  assign in_plane.b = s_axis_tdata[3+CW +: CW];
  assign in_plane.c = s_axis_tdata[3+2*CW +: CW];
  assign in_plane.d = s_axis_tdata[3+3*CW +: CW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_in[k] = s_axis_tdata[3+(4+k)*CW +: CW];
      // a point uses its own coordinates as both corners
      hi_in[k] = (mode == fbc_pkg::ModeBox) ? s_axis_tdata[3+(7+k)*CW +: CW]
                                            : s_axis_tdata[3+(4+k)*CW +: CW];
    end
  end

  // plane store, loads write at transfer time
  fbc_pkg::plane_t planes_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) planes_q[p] <= '0;
    end else if (in_fire && mode == fbc_pkg::ModeLoad) begin
      for (int p = 0; p < NP; p++) begin
        if (idx == fbc_pkg::PlaneIdxW'(p)) planes_q[p] <= in_plane;
      end
    end
  end

  // stage 1: registered test item with a snapshot of the planes it sees,
  // so a load right behind it cannot reach it further down the pipe
  logic s1_vld_q;
  logic signed [CW-1:0] s1_lo_q [3];
  logic signed [CW-1:0] s1_hi_q [3];
  fbc_pkg::plane_t      s1_planes_q [NP];
  logic test_item;
  assign test_item = (mode == fbc_pkg::ModePoint) || (mode == fbc_pkg::ModeBox);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_fire && test_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lo_q     <= lo_in;
      s1_hi_q     <= hi_in;
      s1_planes_q <= planes_q;
    end
  end

  // stage 2: products for both corners on every axis of every plane
  logic s2_vld_q;
  logic signed [PW-1:0] s2_plo_q [NP][3];
  logic signed [PW-1:0] s2_phi_q [NP][3];
  logic signed [PW-1:0] s2_d_q   [NP];
  logic signed [CW-1:0] coef [NP][3];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      coef[p][0] = s1_planes_q[p].a;
      coef[p][1] = s1_planes_q[p].b;
      coef[p][2] = s1_planes_q[p].c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < NP; p++) begin
        for (int k = 0; k < 3; k++) begin
          s2_plo_q[p][k] <= PW'(coef[p][k] * s1_lo_q[k]);
          s2_phi_q[p][k] <= PW'(coef[p][k] * s1_hi_q[k]);
        end
        // d scaled to Q32.32
        s2_d_q[p] <= {{(PW-CW-16){s1_planes_q[p].d[CW-1]}}, s1_planes_q[p].d, 16'h0000};
      end
    end
  end

  // stage 3: pick the corner furthest in front per axis, add two terms
  logic s3_vld_q;
  logic signed [SW-1:0] s3_ab_q [NP];
  logic signed [SW-1:0] s3_cd_q [NP];
  logic signed [PW-1:0] mx [NP][3];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < 3; k++) begin
        mx[p][k] = (s2_plo_q[p][k] > s2_phi_q[p][k]) ? s2_plo_q[p][k] : s2_phi_q[p][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < NP; p++) begin
        s3_ab_q[p] <= SW'(mx[p][0]) + SW'(mx[p][1]);
        s3_cd_q[p] <= SW'(mx[p][2]) + SW'(s2_d_q[p]);
      end
    end
  end

  // stage 4: final sum, sign test and result register
  logic [NP-1:0] behind;
  logic signed [SW-1:0] tot [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      tot[p]    = s3_ab_q[p] + s3_cd_q[p];
      behind[p] = tot[p][SW-1];
    end
  end

  logic vis_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) vis_q <= ~|behind;
  end

  assign m_axis_tdata = {{(fbc_pkg::OutDataW-1){1'b0}}, vis_q};

endmodule

`default_nettype wire
